// ===== hw/rtl/pgl_pkg.sv =====
// ----------------------------------------------------------------------------
// pgl_pkg
// Shared types and constants for the palette gamma line writer.
// ----------------------------------------------------------------------------
package pgl_pkg;

   localparam logic [2:0] ACT_PIXEL   = 3'd0;
   localparam logic [2:0] ACT_PALETTE = 3'd1;
   localparam logic [2:0] ACT_RED     = 3'd2;
   localparam logic [2:0] ACT_GREEN   = 3'd3;
   localparam logic [2:0] ACT_BLUE    = 3'd4;

   localparam int RED_BITS   = 5;
   localparam int GREEN_BITS = 6;
   localparam int BLUE_BITS  = 5;

   typedef struct packed {
      logic        visible;
      logic [16:0] screen_x;
      logic [15:0] screen_y;
      logic        run_start;
   } pixel_type;

endpackage

// ===== hw/rtl/pgl_palette_mem.sv =====
// ----------------------------------------------------------------------------
// pgl_palette_mem
// 256 x 16 palette memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pgl_palette_mem (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [7:0]  wr_addr,
   input  logic [15:0] wr_data,
   input  logic        rd_en,
   input  logic [7:0]  rd_addr,
   output logic [15:0] rd_data
);

   logic [15:0] mem [256];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pgl_curve_mem.sv =====
// ----------------------------------------------------------------------------
// pgl_curve_mem
// Gamma curve memory that reads as the identity mapping until written.
// ----------------------------------------------------------------------------
module pgl_curve_mem #(
   parameter int WIDTH = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   localparam int DEPTH = 2 ** WIDTH;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] written_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic [WIDTH-1:0] rd_addr_ff;
   logic             rd_written_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff    <= mem[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
         rd_addr_ff    <= rd_addr;
      end
   end

   // An entry never written returns its own address.
   assign rd_data = rd_written_ff ? rd_data_ff : rd_addr_ff;

endmodule

// ===== hw/rtl/pgl_line_tracker.sv =====
// ----------------------------------------------------------------------------
// pgl_line_tracker
// Tracks the position in the line and the run state, and decides visibility.
// ----------------------------------------------------------------------------
module pgl_line_tracker #(
   parameter int SCREEN_WIDTH = 320
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pixel_take,
   input  logic [7:0]          index,
   input  logic [15:0]         x_origin,
   input  logic [15:0]         line_y,
   input  logic                has_transparency,
   input  logic [7:0]          transparent_index,
   input  logic                line_end,
   output pgl_pkg::pixel_type  pixel
);

   localparam logic [15:0] WIDTH_LIMIT = 16'(SCREEN_WIDTH);

   logic [15:0] pos_ff, pos_in;
   logic        prev_ff, prev_in;
   logic        in_range;
   logic        clear_pixel;

   assign in_range    = pos_ff < WIDTH_LIMIT;
   assign clear_pixel = has_transparency && (index == transparent_index);

   assign pixel.visible   = in_range && !clear_pixel;
   assign pixel.screen_x  = {1'b0, x_origin} + {1'b0, pos_ff};
   assign pixel.screen_y  = line_y;
   assign pixel.run_start = !prev_ff;

   always_comb begin
      pos_in  = pos_ff;
      prev_in = prev_ff;
      if (pixel_take) begin
         if (in_range) begin
            prev_in = !clear_pixel;
         end
         if (pos_ff != 16'hFFFF) begin
            pos_in = pos_ff + 16'd1;
         end
         if (line_end) begin
            pos_in  = '0;
            prev_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         prev_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         prev_ff <= prev_in;
      end
   end

endmodule

// ===== hw/rtl/palette_gamma_line_writer_unit.sv =====
// ----------------------------------------------------------------------------
// palette_gamma_line_writer_unit
// Palette lookup and gamma correction of scanline pixels into RGB565 writes.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while the result side keeps up. A
// visible pixel is registered first by the palette memory read and then by
// the gamma curve reads, whose registers drive the result port; a stall on
// the result side can hold it in between. Write requests and pixels that
// give no result leave no trace on the result port. Backpressure moves up
// one stage at a time, so the request side keeps going while empty slots
// remain in the pipeline.
module palette_gamma_line_writer_unit #(
   parameter int SCREEN_WIDTH = 320
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_index,
   input  logic [15:0] req_value,
   input  logic [15:0] req_x_origin,
   input  logic [15:0] req_line_y,
   input  logic        req_has_transparency,
   input  logic [7:0]  req_transparent_index,
   input  logic        req_line_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [16:0] rsp_screen_x,
   output logic [15:0] rsp_screen_y,
   output logic [15:0] rsp_color,
   output logic        rsp_run_start
);

   pgl_pkg::pixel_type trk_pixel;
   logic               take, is_pixel, is_curve_wr, s1_load;

   logic               s1_valid_ff, s1_valid_in;
   logic [2:0]         s1_action_ff;
   pgl_pkg::pixel_type s1_pixel_ff;
   logic [5:0]         s1_waddr_ff;
   logic [5:0]         s1_wval_ff;
   logic               s1_is_pixel, s1_go, s1_free;

   logic               s2_valid_ff, s2_valid_in, s2_free;
   pgl_pkg::pixel_type s2_pixel_ff;

   logic [15:0]        pal_data;
   logic               curve_rd;
   logic [4:0]         red_q, blue_q;
   logic [5:0]         green_q;

   assign take        = req_valid && req_ready;
   assign is_pixel    = req_action == pgl_pkg::ACT_PIXEL;
   assign is_curve_wr = (req_action == pgl_pkg::ACT_RED) ||
                        (req_action == pgl_pkg::ACT_GREEN) ||
                        (req_action == pgl_pkg::ACT_BLUE);
   assign s1_load     = take && ((is_pixel && trk_pixel.visible) || is_curve_wr);

   pgl_line_tracker #(
      .SCREEN_WIDTH(SCREEN_WIDTH)
   ) u_tracker (
      .clock            (clock),
      .reset            (reset),
      .pixel_take       (take && is_pixel),
      .index            (req_index),
      .x_origin         (req_x_origin),
      .line_y           (req_line_y),
      .has_transparency (req_has_transparency),
      .transparent_index(req_transparent_index),
      .line_end         (req_line_end),
      .pixel            (trk_pixel)
   );

   pgl_palette_mem u_palette (
      .clock  (clock),
      .wr_en  (take && (req_action == pgl_pkg::ACT_PALETTE)),
      .wr_addr(req_index),
      .wr_data(req_value),
      .rd_en  (s1_load && is_pixel),
      .rd_addr(req_index),
      .rd_data(pal_data)
   );

   // Handshake across the two stages.
   assign s2_free     = !s2_valid_ff || rsp_ready;
   assign s1_is_pixel = s1_action_ff == pgl_pkg::ACT_PIXEL;
   assign s1_go       = s1_valid_ff && (!s1_is_pixel || s2_free);
   assign s1_free     = !s1_valid_ff || s1_go;
   assign req_ready   = s1_free;
   assign s1_valid_in = s1_free ? s1_load : s1_valid_ff;
   assign s2_valid_in = (s1_go && s1_is_pixel) || (s2_valid_ff && !rsp_ready);
   assign curve_rd    = s1_go && s1_is_pixel;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && s1_load) begin
         s1_action_ff <= req_action;
         s1_pixel_ff  <= trk_pixel;
         s1_waddr_ff  <= req_index[5:0];
         s1_wval_ff   <= req_value[5:0];
      end
      if (curve_rd) begin
         s2_pixel_ff <= s1_pixel_ff;
      end
   end

   // Curve writes take effect as they leave the first stage, in request order
   // with the pixel reads of the same curves.
   pgl_curve_mem #(
      .WIDTH(pgl_pkg::RED_BITS)
   ) u_red (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (s1_go && (s1_action_ff == pgl_pkg::ACT_RED)),
      .wr_addr(s1_waddr_ff[4:0]),
      .wr_data(s1_wval_ff[4:0]),
      .rd_en  (curve_rd),
      .rd_addr(pal_data[15:11]),
      .rd_data(red_q)
   );

   pgl_curve_mem #(
      .WIDTH(pgl_pkg::GREEN_BITS)
   ) u_green (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (s1_go && (s1_action_ff == pgl_pkg::ACT_GREEN)),
      .wr_addr(s1_waddr_ff),
      .wr_data(s1_wval_ff),
      .rd_en  (curve_rd),
      .rd_addr(pal_data[10:5]),
      .rd_data(green_q)
   );

   pgl_curve_mem #(
      .WIDTH(pgl_pkg::BLUE_BITS)
   ) u_blue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (s1_go && (s1_action_ff == pgl_pkg::ACT_BLUE)),
      .wr_addr(s1_waddr_ff[4:0]),
      .wr_data(s1_wval_ff[4:0]),
      .rd_en  (curve_rd),
      .rd_addr(pal_data[4:0]),
      .rd_data(blue_q)
   );

   assign rsp_valid     = s2_valid_ff;
   assign rsp_screen_x  = s2_pixel_ff.screen_x;
   assign rsp_screen_y  = s2_pixel_ff.screen_y;
   assign rsp_run_start = s2_pixel_ff.run_start;
   assign rsp_color     = {red_q, green_q, blue_q};

endmodule

// ===== dv/tb_palette_gamma_line_writer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_palette_gamma_line_writer_unit
// Self-checking bench for the palette gamma line writer.
// ----------------------------------------------------------------------------
// Requests load the palette and the gamma curves, then stream scanlines of
// palette indices through the unit. A scoreboard keeps its own copy of the
// tables and line state. It predicts each screen write and compares it
// with what comes out of the result port. The run covers a directed
// opening, random lines under two idling mixes and one mix without idling,
// and a short closing line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_palette_gamma_line_writer_unit;

   localparam int SCREEN_WIDTH = 320;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   class pixel_scoreboard;
      typedef struct {
         logic [16:0] screen_x;
         logic [15:0] screen_y;
         logic [15:0] color;
         logic        run_start;
      } screen_write_type;

      logic [15:0]      palette_mem [256];
      logic [4:0]       red_lut [32];
      logic [5:0]       green_lut [64];
      logic [4:0]       blue_lut [32];
      logic [15:0]      line_pos;
      logic             prev_visible;
      screen_write_type writes_due [$];
      int               mismatches;

      function new();
         for (int i = 0; i < 64; i++) begin
            green_lut[i] = 6'(i);
            if (i < 32) begin
               red_lut[i]  = 5'(i);
               blue_lut[i] = 5'(i);
            end
         end
         line_pos     = '0;
         prev_visible = 1'b0;
         mismatches   = 0;
      endfunction

      function void note_request(logic [2:0] action, logic [7:0] index, logic [15:0] value,
                                 logic [15:0] x_origin, logic [15:0] line_y,
                                 logic has_transparency, logic [7:0] transparent_index,
                                 logic line_end);
         screen_write_type w;
         logic [15:0]      raw;
         case (action)
            pgl_pkg::ACT_PALETTE: palette_mem[index] = value;
            pgl_pkg::ACT_RED:     red_lut[index[4:0]] = value[4:0];
            pgl_pkg::ACT_GREEN:   green_lut[index[5:0]] = value[5:0];
            pgl_pkg::ACT_BLUE:    blue_lut[index[4:0]] = value[4:0];
            pgl_pkg::ACT_PIXEL: begin
               if (line_pos < SCREEN_WIDTH) begin
                  if (has_transparency && index == transparent_index) begin
                     prev_visible = 1'b0;
                  end else begin
                     raw         = palette_mem[index];
                     w.screen_x  = {1'b0, x_origin} + {1'b0, line_pos};
                     w.screen_y  = line_y;
                     w.color     = {red_lut[raw[15:11]], green_lut[raw[10:5]],
                                    blue_lut[raw[4:0]]};
                     w.run_start = !prev_visible;
                     prev_visible = 1'b1;
                     writes_due.push_back(w);
                  end
               end
               if (line_pos != 16'hFFFF) begin
                  line_pos = line_pos + 16'd1;
               end
               if (line_end) begin
                  line_pos     = '0;
                  prev_visible = 1'b0;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_write(logic [16:0] screen_x, logic [15:0] screen_y,
                                logic [15:0] color, logic run_start);
         screen_write_type w;
         if (writes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected write: x=%0d y=%0d color=%h run_start=%0d",
                        screen_x, screen_y, color, run_start);
            end
            return;
         end
         w = writes_due.pop_front();
         if (w.screen_x !== screen_x || w.screen_y !== screen_y ||
             w.color !== color || w.run_start !== run_start) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Write mismatch: expected x=%0d y=%0d color=%h run_start=%0d",
                        w.screen_x, w.screen_y, w.color, w.run_start);
               $display("                actual   x=%0d y=%0d color=%h run_start=%0d",
                        screen_x, screen_y, color, run_start);
            end
         end
      endfunction

      function int pending();
         return writes_due.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_action;
   logic [7:0]  req_index;
   logic [15:0] req_value;
   logic [15:0] req_x_origin;
   logic [15:0] req_line_y;
   logic        req_has_transparency;
   logic [7:0]  req_transparent_index;
   logic        req_line_end;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [16:0] rsp_screen_x;
   logic [15:0] rsp_screen_y;
   logic [15:0] rsp_color;
   logic        rsp_run_start;

   pixel_scoreboard sb;
   int              send_idle_pct;
   int              recv_stall_pct;
   int              requests_sent;
   int              quiet_cycles;
   bit              palette_written [256];
   logic [7:0]      written_entries [$];

   palette_gamma_line_writer_unit #(
      .SCREEN_WIDTH(SCREEN_WIDTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_index(req_index),
      .req_value(req_value),
      .req_x_origin(req_x_origin),
      .req_line_y(req_line_y),
      .req_has_transparency(req_has_transparency),
      .req_transparent_index(req_transparent_index),
      .req_line_end(req_line_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_screen_x(rsp_screen_x),
      .rsp_screen_y(rsp_screen_y),
      .rsp_color(rsp_color),
      .rsp_run_start(rsp_run_start)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_write(rsp_screen_x, rsp_screen_y, rsp_color, rsp_run_start);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send(input logic [2:0] action, input logic [7:0] index,
                       input logic [15:0] value, input logic [15:0] x_origin,
                       input logic [15:0] line_y, input logic has_transparency,
                       input logic [7:0] transparent_index, input logic line_end);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_action            = action;
      req_index             = index;
      req_value             = value;
      req_x_origin          = x_origin;
      req_line_y            = line_y;
      req_has_transparency  = has_transparency;
      req_transparent_index = transparent_index;
      req_line_end          = line_end;
      req_valid             = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sb.note_request(action, index, value, x_origin, line_y, has_transparency,
                      transparent_index, line_end);
      if (action == pgl_pkg::ACT_PALETTE && !palette_written[index]) begin
         palette_written[index] = 1'b1;
         written_entries.push_back(index);
      end
      if (action <= pgl_pkg::ACT_BLUE) begin
         requests_sent++;
      end
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_entry();
      return written_entries[$urandom_range(0, written_entries.size() - 1)];
   endfunction

   task automatic send_noise_write();
      int          roll;
      logic [2:0]  action;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         action = pgl_pkg::ACT_PALETTE;
      end else if (roll < 92) begin
         action = 3'($urandom_range(pgl_pkg::ACT_RED, pgl_pkg::ACT_BLUE));
      end else begin
         action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      end
      send(action, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           1'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic send_line(input int length, input bit close_line);
      logic [15:0] x0;
      logic [15:0] y;
      logic        has_t;
      logic [7:0]  t_idx;
      logic [7:0]  idx;
      int          p;
      x0    = 16'($urandom);
      y     = 16'($urandom);
      has_t = 1'($urandom);
      t_idx = $urandom_range(0, 1) ? pick_entry() : 8'($urandom);
      p     = 0;
      while (p < length) begin
         if ($urandom_range(0, 99) < 18) begin
            send_noise_write();
         end else begin
            idx = (has_t && $urandom_range(0, 3) == 0) ? t_idx : pick_entry();
            send(pgl_pkg::ACT_PIXEL, idx, 16'($urandom), x0, y, has_t, t_idx,
                 close_line && p == length - 1);
            p++;
         end
      end
   endtask

   task automatic run_random_lines(input int target);
      int length;
      while (requests_sent < target) begin
         length = ($urandom_range(0, 99) < 4) ? $urandom_range(300, 340)
                                              : $urandom_range(1, 40);
         send_line(length, $urandom_range(0, 9) != 0);
      end
   endtask

   initial begin
      sb                    = new();
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_action            = pgl_pkg::ACT_PIXEL;
      req_index             = '0;
      req_value             = '0;
      req_x_origin          = '0;
      req_line_y            = '0;
      req_has_transparency  = 1'b0;
      req_transparent_index = '0;
      req_line_end          = 1'b0;
      rsp_ready             = 1'b0;
      send_idle_pct         = 29;
      recv_stall_pct        = 85;
      requests_sent         = 0;
      quiet_cycles          = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(pgl_pkg::ACT_PALETTE, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
      send(pgl_pkg::ACT_PALETTE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 1'b1);
      send(pgl_pkg::ACT_PALETTE, 8'h5A, 16'hA55A, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
      send(pgl_pkg::ACT_PIXEL, 8'hFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 8'hFF, 1'b0);
      send(pgl_pkg::ACT_PIXEL, 8'h00, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 1'b0);
      send(pgl_pkg::ACT_PIXEL, 8'h5A, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, 8'h5A, 1'b0);
      send(pgl_pkg::ACT_PIXEL, 8'hFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, 8'h5A, 1'b1);
      send(pgl_pkg::ACT_RED, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1);
      send(pgl_pkg::ACT_GREEN, 8'hFF, 16'hFFC1, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1);
      send(pgl_pkg::ACT_BLUE, 8'hE0, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
      for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) begin
         send(3'(a), 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 1'b1);
      end
      send(pgl_pkg::ACT_PIXEL, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
      send(pgl_pkg::ACT_PIXEL, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1);
      send(pgl_pkg::ACT_PIXEL, 8'h5A, 16'hFFFF, 16'h1234, 16'h4321, 1'b1, 8'h00, 1'b1);

      run_random_lines(480);
      send_idle_pct  = 85;
      recv_stall_pct = 29;
      run_random_lines(960);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random_lines(1450);

      send_line(5, 1'b1);

      req_valid = 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/pgl_pkg.sv
hw/rtl/pgl_palette_mem.sv
hw/rtl/pgl_curve_mem.sv
hw/rtl/pgl_line_tracker.sv
hw/rtl/palette_gamma_line_writer_unit.sv
dv/tb_palette_gamma_line_writer_unit.sv
